/* design/sic_pkg.sv */
// Shared types and constants for the segment intersection test.
package sic_pkg;

	// Width of each coordinate field on the ports
	localparam int CoordBits = 16;
	// Width of a position code
	localparam int CodeBits = 3;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic signed [CodeBits-1:0]  code_t;

	// Position codes of a point against a directed segment
	localparam code_t CODE_ON     = 3'sd0;
	localparam code_t CODE_LEFT   = 3'sd1;
	localparam code_t CODE_RIGHT  = -3'sd1;
	localparam code_t CODE_BEYOND = 3'sd2;
	localparam code_t CODE_BEHIND = -3'sd2;

	// Load enables of the pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} sic_adv_t;

endpackage

/* design/sic_if.sv */
// Valid/ready channels for segment pairs and intersection results.
interface sic_pair_if;
	logic           valid;
	logic           ready;
	sic_pkg::coord_t a_start_x;
	sic_pkg::coord_t a_start_y;
	sic_pkg::coord_t a_end_x;
	sic_pkg::coord_t a_end_y;
	sic_pkg::coord_t b_start_x;
	sic_pkg::coord_t b_start_y;
	sic_pkg::coord_t b_end_x;
	sic_pkg::coord_t b_end_y;

	modport source (
		output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		output b_start_x, b_start_y, b_end_x, b_end_y,
		input  ready
	);
	modport sink (
		input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
		input  b_start_x, b_start_y, b_end_x, b_end_y,
		output ready
	);
endinterface

interface sic_result_if;
	logic           valid;
	logic           ready;
	logic           segments_meet;
	sic_pkg::code_t code_b_start;
	sic_pkg::code_t code_b_end;
	sic_pkg::code_t code_a_start;
	sic_pkg::code_t code_a_end;

	modport source (
		output valid, segments_meet, code_b_start, code_b_end, code_a_start, code_a_end,
		input  ready
	);
	modport sink (
		input  valid, segments_meet, code_b_start, code_b_end, code_a_start, code_a_end,
		output ready
	);
endinterface

/* design/segment_intersection_test.sv */
// A pair passes registered stages 1, 2, 3 and 4 before its result is offered.
// Throughput: one segment pair per cycle unless result.ready is low; the multiplier
// stage (stage 2) and the cross/dot sum stage (stage 3) set the clock period.
// A stalled result holds in the output stage while earlier stages keep filling.
// Reset (arst_n low) clears only the stage valid bits; no data is kept.
module segment_intersection_test #(
	parameter int COORD_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	sic_pair_if.sink      pair,
	sic_result_if.source  result
);

	sic_pkg::sic_adv_t adv;
	logic              valid_s1, valid_s2, valid_s3, valid_s4;

	sic_pkg::code_t cbs_s3, cbe_s3, cas_s3, cae_s3;
	sic_pkg::code_t cbs_s4, cbe_s4, cas_s4, cae_s4;
	logic           meet_d, meet_s4;

	// Advance a stage when it is empty or its successor advances
	assign adv.s4     = !valid_s4 || result.ready;
	assign adv.s3     = !valid_s3 || adv.s4;
	assign adv.s2     = !valid_s2 || adv.s3;
	assign adv.s1     = !valid_s1 || adv.s2;
	assign pair.ready = adv.s1;

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv.s1) valid_s1 <= pair.valid;
			if (adv.s2) valid_s2 <= valid_s1;
			if (adv.s3) valid_s3 <= valid_s2;
			if (adv.s4) valid_s4 <= valid_s3;
		end
	end

	// Classify each endpoint against the other segment
	sic_code #(.COORD_WIDTH(COORD_WIDTH)) u_code_bs (
		.clk(clk), .adv(adv),
		.px(pair.a_start_x), .py(pair.a_start_y), .qx(pair.a_end_x), .qy(pair.a_end_y),
		.rx(pair.b_start_x), .ry(pair.b_start_y), .code_s3(cbs_s3)
	);
	sic_code #(.COORD_WIDTH(COORD_WIDTH)) u_code_be (
		.clk(clk), .adv(adv),
		.px(pair.a_start_x), .py(pair.a_start_y), .qx(pair.a_end_x), .qy(pair.a_end_y),
		.rx(pair.b_end_x), .ry(pair.b_end_y), .code_s3(cbe_s3)
	);
	sic_code #(.COORD_WIDTH(COORD_WIDTH)) u_code_as (
		.clk(clk), .adv(adv),
		.px(pair.b_start_x), .py(pair.b_start_y), .qx(pair.b_end_x), .qy(pair.b_end_y),
		.rx(pair.a_start_x), .ry(pair.a_start_y), .code_s3(cas_s3)
	);
	sic_code #(.COORD_WIDTH(COORD_WIDTH)) u_code_ae (
		.clk(clk), .adv(adv),
		.px(pair.b_start_x), .py(pair.b_start_y), .qx(pair.b_end_x), .qy(pair.b_end_y),
		.rx(pair.a_end_x), .ry(pair.a_end_y), .code_s3(cae_s3)
	);

	// Code product not positive: either code zero or signs differ
	assign meet_d = ((cbs_s3 == sic_pkg::CODE_ON) || (cbe_s3 == sic_pkg::CODE_ON) ||
	                 (cbs_s3[2] != cbe_s3[2])) &&
	                ((cas_s3 == sic_pkg::CODE_ON) || (cae_s3 == sic_pkg::CODE_ON) ||
	                 (cas_s3[2] != cae_s3[2]));

	// Stage 4: output register
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			meet_s4 <= meet_d;
			cbs_s4  <= cbs_s3;
			cbe_s4  <= cbe_s3;
			cas_s4  <= cas_s3;
			cae_s4  <= cae_s3;
		end
	end

	assign result.valid         = valid_s4;
	assign result.segments_meet = meet_s4;
	assign result.code_b_start  = cbs_s4;
	assign result.code_b_end    = cbe_s4;
	assign result.code_a_start  = cas_s4;
	assign result.code_a_end    = cae_s4;

	// An accepted pair enters stage 1
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pair.valid && pair.ready |=> valid_s1)
		else $error("accepted pair did not enter stage 1");

	// A stalled stage 3 keeps its item
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !adv.s3 |=> valid_s3)
		else $error("stalled stage 3 dropped its item");

	// Ready toward the source only when stage 1 can take data
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pair.ready |-> !valid_s1 || adv.s2)
		else $error("ready raised while stage 1 is blocked");

	// An endpoint on each segment always means the segments meet
	a_meet_on: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.code_b_start == sic_pkg::CODE_ON) &&
		(result.code_a_start == sic_pkg::CODE_ON) |-> result.segments_meet)
		else $error("touching endpoints reported as apart");

	// Both ends of B on the left of A mean no meeting
	a_apart: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.code_b_start == sic_pkg::CODE_LEFT) &&
		(result.code_b_end == sic_pkg::CODE_LEFT) |-> !result.segments_meet)
		else $error("segment on one side reported as meeting");

endmodule

/* design/sic_code.sv */
// Three-stage position code of one point against one segment.
module sic_code #(
	parameter int COORD_WIDTH = 16
) (
	input  logic              clk,
	input  sic_pkg::sic_adv_t adv,
	input  sic_pkg::coord_t   px,
	input  sic_pkg::coord_t   py,
	input  sic_pkg::coord_t   qx,
	input  sic_pkg::coord_t   qy,
	input  sic_pkg::coord_t   rx,
	input  sic_pkg::coord_t   ry,
	output sic_pkg::code_t    code_s3
);

	localparam int W  = COORD_WIDTH;
	localparam int DW = W + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 1;
	localparam int FW = sic_pkg::CoordBits;

	logic signed [W-1:0] px_c, py_c, qx_c, qy_c, rx_c, ry_c;

	logic signed [DW-1:0] ux_s1, uy_s1, wx_s1, wy_s1, vx_s1, vy_s1;

	logic signed [PW-1:0] cross_a_s2, cross_b_s2;
	logic signed [PW-1:0] dotq_a_s2, dotq_b_s2;
	logic signed [PW-1:0] dotp_a_s2, dotp_b_s2;
	logic                 degen_s2, at_p_s2;

	logic signed [SW-1:0] cross_sum, dotq_sum, dotp_sum;
	sic_pkg::code_t       code_d;

	// Keep the low coordinate bits and treat bit W-1 as the sign
	function automatic logic signed [W-1:0] trim(input sic_pkg::coord_t f);
		logic [W+FW-1:0] ext;
		ext = {{W{1'b0}}, f};
		return ext[W-1:0];
	endfunction

	assign px_c = trim(px);
	assign py_c = trim(py);
	assign qx_c = trim(qx);
	assign qy_c = trim(qy);
	assign rx_c = trim(rx);
	assign ry_c = trim(ry);

	// Stage 1: edge and offset vectors
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			ux_s1 <= DW'(qx_c) - DW'(px_c);
			uy_s1 <= DW'(qy_c) - DW'(py_c);
			wx_s1 <= DW'(rx_c) - DW'(px_c);
			wy_s1 <= DW'(ry_c) - DW'(py_c);
			vx_s1 <= DW'(rx_c) - DW'(qx_c);
			vy_s1 <= DW'(ry_c) - DW'(qy_c);
		end
	end

	// Stage 2: partial products of cross and dot terms
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			cross_a_s2 <= PW'(ux_s1) * PW'(wy_s1);
			cross_b_s2 <= PW'(uy_s1) * PW'(wx_s1);
			dotq_a_s2  <= PW'(ux_s1) * PW'(vx_s1);
			dotq_b_s2  <= PW'(uy_s1) * PW'(vy_s1);
			dotp_a_s2  <= PW'(ux_s1) * PW'(wx_s1);
			dotp_b_s2  <= PW'(uy_s1) * PW'(wy_s1);
			degen_s2   <= (ux_s1 == '0) && (uy_s1 == '0);
			at_p_s2    <= (wx_s1 == '0) && (wy_s1 == '0);
		end
	end

	// Stage 3: combine products and pick the code
	assign cross_sum = SW'(cross_a_s2) - SW'(cross_b_s2);
	assign dotq_sum  = SW'(dotq_a_s2) + SW'(dotq_b_s2);
	assign dotp_sum  = SW'(dotp_a_s2) + SW'(dotp_b_s2);

	always_comb begin
		if (degen_s2) begin
			code_d = at_p_s2 ? sic_pkg::CODE_ON : sic_pkg::CODE_BEHIND;
		end else if (cross_sum > 0) begin
			code_d = sic_pkg::CODE_LEFT;
		end else if (cross_sum < 0) begin
			code_d = sic_pkg::CODE_RIGHT;
		end else if (dotq_sum > 0) begin
			code_d = sic_pkg::CODE_BEYOND;
		end else if (dotp_sum < 0) begin
			code_d = sic_pkg::CODE_BEHIND;
		end else begin
			code_d = sic_pkg::CODE_ON;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			code_s3 <= code_d;
		end
	end

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the segment intersection test block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PAIRS = 900;

	typedef struct packed {
		sic_pkg::coord_t a_start_x;
		sic_pkg::coord_t a_start_y;
		sic_pkg::coord_t a_end_x;
		sic_pkg::coord_t a_end_y;
		sic_pkg::coord_t b_start_x;
		sic_pkg::coord_t b_start_y;
		sic_pkg::coord_t b_end_x;
		sic_pkg::coord_t b_end_y;
	} seg_pair_t;

	typedef struct packed {
		logic           meet;
		sic_pkg::code_t code_b_start;
		sic_pkg::code_t code_b_end;
		sic_pkg::code_t code_a_start;
		sic_pkg::code_t code_a_end;
	} verdict_t;

	// Predict the verdict for each pair and hold it until the block answers
	class meet_checker #(int CW = 16);
		verdict_t verdicts[$];
		int       mismatches;

		// Keep the low CW bits of the field and sign-extend from bit CW-1
		function longint widen(sic_pkg::coord_t v);
			longint t;
			t = longint'($unsigned(v));
			return (t <<< (64 - CW)) >>> (64 - CW);
		endfunction

		// Position of r against the directed segment p->q
		function sic_pkg::code_t classify_point(longint px, longint py, longint qx,
				longint qy, longint rx, longint ry);
			longint ux, uy, wx, wy, vx, vy, turn;
			ux = qx - px;
			uy = qy - py;
			wx = rx - px;
			wy = ry - py;
			vx = rx - qx;
			vy = ry - qy;
			// a single point: only the point itself is on it
			if (ux == 0 && uy == 0)
				return (wx == 0 && wy == 0) ? sic_pkg::CODE_ON : sic_pkg::CODE_BEHIND;
			turn = ux * wy - uy * wx;
			if (turn > 0)
				return sic_pkg::CODE_LEFT;
			if (turn < 0)
				return sic_pkg::CODE_RIGHT;
			if (ux * vx + uy * vy > 0)
				return sic_pkg::CODE_BEYOND;
			if (-ux * wx - uy * wy > 0)
				return sic_pkg::CODE_BEHIND;
			return sic_pkg::CODE_ON;
		endfunction

		function verdict_t predict_verdict(seg_pair_t p);
			verdict_t v;
			longint asx, asy, aex, aey, bsx, bsy, bex, bey;
			asx = widen(p.a_start_x);
			asy = widen(p.a_start_y);
			aex = widen(p.a_end_x);
			aey = widen(p.a_end_y);
			bsx = widen(p.b_start_x);
			bsy = widen(p.b_start_y);
			bex = widen(p.b_end_x);
			bey = widen(p.b_end_y);
			v.code_b_start = classify_point(asx, asy, aex, aey, bsx, bsy);
			v.code_b_end   = classify_point(asx, asy, aex, aey, bex, bey);
			v.code_a_start = classify_point(bsx, bsy, bex, bey, asx, asy);
			v.code_a_end   = classify_point(bsx, bsy, bex, bey, aex, aey);
			v.meet = (int'(v.code_b_start) * int'(v.code_b_end) <= 0) &&
				(int'(v.code_a_start) * int'(v.code_a_end) <= 0);
			return v;
		endfunction

		function void note_pair(seg_pair_t p);
			verdicts.push_back(predict_verdict(p));
		endfunction

		function void check_verdict(verdict_t got);
			verdict_t want;
			if (verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: meet=%0d codes %0d %0d %0d %0d",
						got.meet, got.code_b_start, got.code_b_end,
						got.code_a_start, got.code_a_end);
				return;
			end
			want = verdicts.pop_front();
			if (got.meet !== want.meet || got.code_b_start !== want.code_b_start ||
					got.code_b_end !== want.code_b_end ||
					got.code_a_start !== want.code_a_start ||
					got.code_a_end !== want.code_a_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
						want.meet, want.code_b_start, want.code_b_end,
						want.code_a_start, want.code_a_end,
						got.meet, got.code_b_start, got.code_b_end,
						got.code_a_start, got.code_a_end);
			end
		endfunction

		function int pending();
			return verdicts.size();
		endfunction
	endclass

	typedef meet_checker #(COORD_W) ledger_t;

	logic clk;
	logic arst_n;
	logic calm;

	sic_pair_if   pair_ch ();
	sic_result_if result_ch ();

	ledger_t ledger;

	int extreme_vals[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

	segment_intersection_test #(
		.COORD_WIDTH(COORD_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_ch),
		.result (result_ch)
	);

	// Run the clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// End the run if it hangs
	initial begin
		int cycle_count;
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	// Stall the result side at random, except in the calm stretch
	always @(posedge clk) begin
		result_ch.ready <= calm || ($urandom_range(99) >= 24);
	end

	// Record each transfer on both channels
	always @(posedge clk) begin
		if (pair_ch.valid && pair_ch.ready)
			ledger.note_pair('{pair_ch.a_start_x, pair_ch.a_start_y,
				pair_ch.a_end_x, pair_ch.a_end_y,
				pair_ch.b_start_x, pair_ch.b_start_y,
				pair_ch.b_end_x, pair_ch.b_end_y});
		if (result_ch.valid && result_ch.ready)
			ledger.check_verdict('{result_ch.segments_meet, result_ch.code_b_start,
				result_ch.code_b_end, result_ch.code_a_start, result_ch.code_a_end});
	end

	function automatic seg_pair_t mk(int asx, int asy, int aex, int aey,
			int bsx, int bsy, int bex, int bey);
		return '{sic_pkg::coord_t'(asx), sic_pkg::coord_t'(asy),
			sic_pkg::coord_t'(aex), sic_pkg::coord_t'(aey),
			sic_pkg::coord_t'(bsx), sic_pkg::coord_t'(bsy),
			sic_pkg::coord_t'(bex), sic_pkg::coord_t'(bey)};
	endfunction

	function automatic int span(int lo, int hi);
		return int'($urandom_range(hi - lo)) + lo;
	endfunction

	// Mix generic pairs with collinear, degenerate, extreme and touching ones
	function automatic seg_pair_t random_pair();
		seg_pair_t p;
		int kind, bx, by, dx, dy;
		int k[4];
		kind = $urandom_range(99);
		p = {$urandom, $urandom, $urandom, $urandom};
		if (kind < 20) begin
			// tiny box: many collinear, repeated and single-point cases
			p = mk(span(-3, 3), span(-3, 3), span(-3, 3), span(-3, 3),
				span(-3, 3), span(-3, 3), span(-3, 3), span(-3, 3));
		end else if (kind < 45) begin
			// four points on one line
			bx = span(-1000, 1000);
			by = span(-1000, 1000);
			dx = span(-40, 40);
			dy = span(-40, 40);
			foreach (k[i])
				k[i] = span(-4, 4);
			p = mk(bx + k[0] * dx, by + k[0] * dy, bx + k[1] * dx, by + k[1] * dy,
				bx + k[2] * dx, by + k[2] * dy, bx + k[3] * dx, by + k[3] * dy);
		end else if (kind < 58) begin
			p = mk(extreme_vals[$urandom_range(6)], extreme_vals[$urandom_range(6)],
				extreme_vals[$urandom_range(6)], extreme_vals[$urandom_range(6)],
				extreme_vals[$urandom_range(6)], extreme_vals[$urandom_range(6)],
				extreme_vals[$urandom_range(6)], extreme_vals[$urandom_range(6)]);
		end else if (kind < 68) begin
			// second start on the middle of the first segment
			p = mk(2 * span(-16000, 16000), 2 * span(-16000, 16000),
				2 * span(-16000, 16000), 2 * span(-16000, 16000), 0, 0,
				span(-32768, 32767), span(-32768, 32767));
			p.b_start_x = sic_pkg::coord_t'((int'(p.a_start_x) + int'(p.a_end_x)) / 2);
			p.b_start_y = sic_pkg::coord_t'((int'(p.a_start_y) + int'(p.a_end_y)) / 2);
		end else if (kind < 78) begin
			// shared endpoint
			if ($urandom_range(1)) begin
				p.b_end_x = p.a_start_x;
				p.b_end_y = p.a_start_y;
			end else begin
				p.b_start_x = p.a_end_x;
				p.b_start_y = p.a_end_y;
			end
		end
		return p;
	endfunction

	// Offer one pair and hold it until the transfer
	task automatic send_pair(seg_pair_t p);
		while (!calm && $urandom_range(99) < 24) begin
			pair_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pair_ch.valid     <= 1'b1;
		pair_ch.a_start_x <= p.a_start_x;
		pair_ch.a_start_y <= p.a_start_y;
		pair_ch.a_end_x   <= p.a_end_x;
		pair_ch.a_end_y   <= p.a_end_y;
		pair_ch.b_start_x <= p.b_start_x;
		pair_ch.b_start_y <= p.b_start_y;
		pair_ch.b_end_x   <= p.b_end_x;
		pair_ch.b_end_y   <= p.b_end_y;
		do
			@(posedge clk);
		while (!pair_ch.ready);
	endtask

	// Hold off the sender until every pending verdict has come back
	task automatic drain();
		pair_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (ledger.pending() != 0);
	endtask

	initial begin
		ledger = new();
		calm = 1'b0;
		arst_n <= 1'b0;
		pair_ch.valid     <= 1'b0;
		pair_ch.a_start_x <= '0;
		pair_ch.a_start_y <= '0;
		pair_ch.a_end_x   <= '0;
		pair_ch.a_end_y   <= '0;
		pair_ch.b_start_x <= '0;
		pair_ch.b_start_y <= '0;
		pair_ch.b_end_x   <= '0;
		pair_ch.b_end_y   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed pairs: crossings, touches, collinear layouts, points, extremes
		send_pair(mk(-10, 0, 10, 0, 0, -10, 0, 10));
		send_pair(mk(0, 0, 10, 0, 0, 5, 10, 5));
		send_pair(mk(0, 0, 5, 5, 5, 5, 10, 0));
		send_pair(mk(0, 0, 10, 0, 5, 0, 5, 8));
		send_pair(mk(0, 0, 10, 0, 5, 0, 15, 0));
		send_pair(mk(0, 0, 4, 0, 6, 0, 9, 0));
		send_pair(mk(0, 0, 4, 0, -9, 0, -6, 0));
		send_pair(mk(2, 2, 3, 3, 0, 0, 9, 9));
		send_pair(mk(0, 0, 4, 0, 4, 0, 8, 0));
		send_pair(mk(10, 0, 0, 0, -5, 0, -1, 0));
		send_pair(mk(0, -5, 0, 5, 0, 7, 0, 9));
		send_pair(mk(0, 0, 10, 10, 6, 5, 20, 5));
		send_pair(mk(3, 3, 3, 3, 0, 0, 6, 6));
		send_pair(mk(3, 4, 3, 4, 0, 0, 6, 6));
		send_pair(mk(7, -7, 7, -7, 7, -7, 7, -7));
		send_pair(mk(7, -7, 7, -7, 8, -7, 8, -7));
		send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		send_pair(mk(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767));
		send_pair(mk(-32768, -32768, 32767, 32767, -32767, -32767, 32766, 32766));
		send_pair(mk(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
		send_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768));
		send_pair(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
		send_pair(mk(-1, -1, -1, -1, 0, 0, 1, 1));
		drain();

		// Random pairs, with one calm stretch and one full drain midway
		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			calm = (n >= 300 && n < 450);
			if (n == 600)
				drain();
			send_pair(random_pair());
		end
		calm = 1'b0;
		drain();
		repeat (8) @(posedge clk);

		if (ledger.mismatches == 0 && ledger.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

/* segment_intersection_test.f */
design/sic_pkg.sv
design/sic_if.sv
design/sic_code.sv
design/segment_intersection_test.sv
dv/tb_top.sv
